// ===== sv/i2c_master_byte_engine_unit_macros.svh =====
// Assertion macros used by the checker file of the byte engine.
// No dependencies; include by bare file name.
`ifndef I2C_MASTER_BYTE_ENGINE_UNIT_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_UNIT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define I2CMBE_CHECK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also holds through reset.
`define I2CMBE_CHECK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/i2cmbe_pkg.sv =====
// Shared types and constants of the I2C master byte engine.
// No dependencies; compile first.
`timescale 1ns / 1ps

package i2cmbe_pkg;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned DELAY_W  = 16;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd100;
  localparam logic [CNT_W-1:0]   BITS_PER_BYTE = 4'd8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_NONE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_STOP  = 2'd3
  } opcode_t;

  // Register index of delay_ticks, taken from paddr[2].
  localparam logic REG_DELAY = 1'b0;

endpackage

// ===== sv/i2cmbe_if.sv =====
// Request and result channel interfaces of the I2C master byte engine.
// Depends on i2cmbe_pkg.
`timescale 1ns / 1ps

interface i2cmbe_in_if
  import i2cmbe_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [BYTE_W-1:0]   tx_byte;
  logic                with_start;
  logic                with_stop;
  logic                send_ack;
  logic                sda_in;

  modport source (output valid, opcode, tx_byte, with_start, with_stop, send_ack, sda_in,
                  input ready);
  modport sink   (input valid, opcode, tx_byte, with_start, with_stop, send_ack, sda_in,
                  output ready);
endinterface

interface i2cmbe_out_if
  import i2cmbe_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              scl_out;
  logic              sda_out;
  logic              busy_res;
  logic              done_res;
  logic              nack;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, nack, rx_byte,
                  input ready);
  modport sink   (input valid, scl_out, sda_out, busy_res, done_res, nack, rx_byte,
                  output ready);
endinterface

// ===== sv/i2c_master_byte_engine_unit.sv =====
// Top level of the bit-banged I2C master byte engine.
// Depends on i2cmbe_pkg and the channel interfaces in i2cmbe_if.sv.
//
//   channel  | dir | handshake        | carries
//   in_ch    | in  | valid/ready      | one bus tick: command fields and sampled SDA
//   out_ch   | out | valid/ready      | line levels, busy, done, nack, rx_byte
//   cfg      | in  | APB psel/penable | delay_ticks at byte address 0
//
// One request per clock unless out_ch stalls; its result is registered next cycle.
// The bus sequencer updates in the same edge that captures the result.
// A full result register that is being taken still lets a new request in.
// Reset (rst_n low, synchronous) idles the sequencer with scl_r and sda_r high.
`timescale 1ns / 1ps

module i2c_master_byte_engine_unit
  import i2cmbe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  i2cmbe_in_if.sink          in_ch,
  i2cmbe_out_if.source       out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_ST1   = 4'd1,
    PH_ST2   = 4'd2,
    PH_ST3   = 4'd3,
    PH_WB_LO = 4'd4,
    PH_WB_HI = 4'd5,
    PH_AR_LO = 4'd6,
    PH_AR_HI = 4'd7,
    PH_RD_LO = 4'd8,
    PH_RD_HI = 4'd9,
    PH_AK_LO = 4'd10,
    PH_AK_HI = 4'd11,
    PH_SP1   = 4'd12,
    PH_SP2   = 4'd13,
    PH_SP3   = 4'd14
  } phase_t;

  logic [DELAY_W-1:0] delay_r;
  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [BYTE_W-1:0]  shift_r, shift_nxt;
  logic [DELAY_W-1:0] wait_r, wait_nxt;
  logic               scl_r, scl_nxt;
  logic               sda_r, sda_nxt;
  logic               stop_flag_r, stop_flag_nxt;
  logic               ack_flag_r, ack_flag_nxt;
  logic [BYTE_W-1:0]  last_rx_r, last_rx_nxt;
  logic               last_nack_r, last_nack_nxt;
  logic               done_nxt;
  logic               do_enter;
  phase_t             enter_ph;
  logic [DELAY_W-1:0] wait_dec;
  logic [DELAY_W-1:0] wait_load;

  logic               out_valid_r;
  logic               res_scl_r, res_sda_r, res_busy_r, res_done_r, res_nack_r;
  logic [BYTE_W-1:0]  res_rx_r;

  logic               accept;
  logic               cfg_write;
  opcode_t            op;

  assign op        = opcode_t'(in_ch.opcode);
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept    = in_ch.valid && in_ch.ready;
  assign wait_load = (delay_r == '0) ? DELAY_W'(1) : delay_r;
  assign wait_dec  = (wait_r != '0) ? wait_r - DELAY_W'(1) : '0;

  always_comb begin
    phase_nxt     = phase_r;
    bit_cnt_nxt   = bit_cnt_r;
    shift_nxt     = shift_r;
    wait_nxt      = wait_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    stop_flag_nxt = stop_flag_r;
    ack_flag_nxt  = ack_flag_r;
    last_rx_nxt   = last_rx_r;
    last_nack_nxt = last_nack_r;
    done_nxt      = 1'b0;
    do_enter      = 1'b0;
    enter_ph      = PH_IDLE;

    if (phase_r == PH_IDLE) begin
      unique case (op)
        OP_WRITE: begin
          shift_nxt     = in_ch.tx_byte;
          bit_cnt_nxt   = '0;
          stop_flag_nxt = in_ch.with_stop;
          ack_flag_nxt  = 1'b0;
          do_enter      = 1'b1;
          enter_ph      = in_ch.with_start ? PH_ST1 : PH_WB_LO;
        end
        OP_READ: begin
          shift_nxt     = '0;
          bit_cnt_nxt   = '0;
          stop_flag_nxt = in_ch.with_stop;
          ack_flag_nxt  = in_ch.send_ack;
          do_enter      = 1'b1;
          enter_ph      = PH_RD_LO;
        end
        OP_STOP: begin
          stop_flag_nxt = 1'b0;
          ack_flag_nxt  = 1'b0;
          do_enter      = 1'b1;
          enter_ph      = PH_SP1;
        end
        default: ;
      endcase
    end else begin
      wait_nxt = wait_dec;
      if (wait_dec == '0) begin
        unique case (phase_r)
          PH_ST1:   begin do_enter = 1'b1; enter_ph = PH_ST2;   end
          PH_ST2:   begin do_enter = 1'b1; enter_ph = PH_ST3;   end
          PH_ST3:   begin do_enter = 1'b1; enter_ph = PH_WB_LO; end
          PH_WB_LO: begin do_enter = 1'b1; enter_ph = PH_WB_HI; end
          PH_WB_HI: begin
            scl_nxt     = 1'b0;
            shift_nxt   = {shift_r[BYTE_W-2:0], 1'b0};
            bit_cnt_nxt = bit_cnt_r + CNT_W'(1);
            do_enter    = 1'b1;
            enter_ph    = (bit_cnt_nxt < BITS_PER_BYTE) ? PH_WB_LO : PH_AR_LO;
          end
          PH_AR_LO: begin do_enter = 1'b1; enter_ph = PH_AR_HI; end
          PH_AR_HI: begin
            last_nack_nxt = in_ch.sda_in;
            scl_nxt       = 1'b0;
            if (stop_flag_r) begin
              do_enter = 1'b1;
              enter_ph = PH_SP1;
            end else begin
              phase_nxt = PH_IDLE;
              wait_nxt  = '0;
              done_nxt  = 1'b1;
            end
          end
          PH_RD_LO: begin do_enter = 1'b1; enter_ph = PH_RD_HI; end
          PH_RD_HI: begin
            shift_nxt   = {shift_r[BYTE_W-2:0], in_ch.sda_in};
            scl_nxt     = 1'b0;
            bit_cnt_nxt = bit_cnt_r + CNT_W'(1);
            do_enter    = 1'b1;
            enter_ph    = (bit_cnt_nxt < BITS_PER_BYTE) ? PH_RD_LO : PH_AK_LO;
          end
          PH_AK_LO: begin do_enter = 1'b1; enter_ph = PH_AK_HI; end
          PH_AK_HI: begin
            scl_nxt     = 1'b0;
            last_rx_nxt = shift_r;
            if (stop_flag_r) begin
              do_enter = 1'b1;
              enter_ph = PH_SP1;
            end else begin
              phase_nxt = PH_IDLE;
              wait_nxt  = '0;
              done_nxt  = 1'b1;
            end
          end
          PH_SP1:   begin do_enter = 1'b1; enter_ph = PH_SP2; end
          PH_SP2:   begin do_enter = 1'b1; enter_ph = PH_SP3; end
          PH_SP3: begin
            phase_nxt = PH_IDLE;
            wait_nxt  = '0;
            done_nxt  = 1'b1;
          end
          default: begin
            phase_nxt = PH_IDLE;
            wait_nxt  = '0;
          end
        endcase
      end
    end

    if (do_enter) begin
      phase_nxt = enter_ph;
      wait_nxt  = wait_load;
      unique case (enter_ph)
        PH_ST1:   begin scl_nxt = 1'b1; sda_nxt = 1'b1; end
        PH_ST2:   sda_nxt = 1'b0;
        PH_ST3:   scl_nxt = 1'b0;
        PH_WB_LO: sda_nxt = shift_nxt[BYTE_W-1];
        PH_AR_LO, PH_RD_LO: sda_nxt = 1'b1;
        PH_AK_LO: sda_nxt = !ack_flag_nxt;
        PH_WB_HI, PH_AR_HI, PH_RD_HI, PH_AK_HI, PH_SP2: scl_nxt = 1'b1;
        PH_SP1:   sda_nxt = 1'b0;
        PH_SP3:   sda_nxt = 1'b1;
        default: begin
          phase_nxt = PH_IDLE;
          wait_nxt  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_cnt_r   <= '0;
      shift_r     <= '0;
      wait_r      <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      stop_flag_r <= 1'b0;
      ack_flag_r  <= 1'b0;
      last_rx_r   <= '0;
      last_nack_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r     <= phase_nxt;
        bit_cnt_r   <= bit_cnt_nxt;
        shift_r     <= shift_nxt;
        wait_r      <= wait_nxt;
        scl_r       <= scl_nxt;
        sda_r       <= sda_nxt;
        stop_flag_r <= stop_flag_nxt;
        ack_flag_r  <= ack_flag_nxt;
        last_rx_r   <= last_rx_nxt;
        last_nack_r <= last_nack_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload: no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      res_scl_r  <= scl_nxt;
      res_sda_r  <= sda_nxt;
      res_busy_r <= (phase_nxt != PH_IDLE);
      res_done_r <= done_nxt;
      res_nack_r <= last_nack_nxt;
      res_rx_r   <= last_rx_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.scl_out  = res_scl_r;
  assign out_ch.sda_out  = res_sda_r;
  assign out_ch.busy_res = res_busy_r;
  assign out_ch.done_res = res_done_r;
  assign out_ch.nack     = res_nack_r;
  assign out_ch.rx_byte  = res_rx_r;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_RESET;
    end else if (cfg_write && (paddr[2] == REG_DELAY)) begin
      delay_r <= pwdata[DELAY_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_DELAY) ? {{(PDATA_W-DELAY_W){1'b0}}, delay_r} : '0;

endmodule

// ===== sv/i2cmbe_checker.sv =====
// Port-level checks of the I2C master byte engine, bound to the top level.
// Depends on i2cmbe_pkg, i2c_master_byte_engine_unit_macros.svh and the top level.
`timescale 1ns / 1ps
`include "i2c_master_byte_engine_unit_macros.svh"

module i2cmbe_checker
  import i2cmbe_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_busy,
  input logic              out_done,
  input logic [BYTE_W-1:0] out_rx
);

  `I2CMBE_CHECK_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result after reset")
  `I2CMBE_CHECK(a_accept_gives_result, clk, rst_n, in_valid && in_ready |=> out_valid, "request without result")
  `I2CMBE_CHECK(a_ready_when_empty, clk, rst_n, !out_valid |-> in_ready, "not ready with empty result register")
  `I2CMBE_CHECK(a_done_not_busy, clk, rst_n, out_valid && out_done |-> !out_busy, "done while busy")
  `I2CMBE_CHECK(a_stall_holds, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_rx), "stalled result changed")

endmodule

bind i2c_master_byte_engine_unit i2cmbe_checker u_i2cmbe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_busy  (out_ch.busy_res),
  .out_done  (out_ch.done_res),
  .out_rx    (out_ch.rx_byte)
);
